// ===== rtl/core/slrs_pkg.sv =====
package slrs_pkg;

  localparam int unsigned NODES_DEF     = 64;
  localparam int unsigned MAX_LEVEL_DEF = 10;
  localparam int unsigned RANGE_LIMIT   = 64;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_MASK = 16'hB400;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_SEARCH = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_NTH    = 3'd3;
  localparam logic [2:0] CMD_RANGE  = 3'd4;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_DELETED  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] marks;
    logic signed [31:0] phone;
  } rec_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WALK,
    S_WALK_N,
    S_WALK_K,
    S_DECIDE,
    S_FREE,
    S_LVL,
    S_INS_RD,
    S_INS_WR,
    S_INS_WR2,
    S_DEL_RD,
    S_DEL_CHK,
    S_DEL_WR,
    S_DEL_FIN,
    S_TRIM,
    S_N_LOOP,
    S_N_LINK,
    S_N_EMIT,
    S_R_CHECK,
    S_R_LINK,
    S_R_REC,
    S_R_NEXT,
    S_EMIT
  } state_e;

  function automatic logic key_less(logic signed [31:0] a, logic signed [31:0] b);
    return a < b;
  endfunction

endpackage

// ===== rtl/core/slrs_if.sv =====
interface slrs_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [31:0] key;
  logic signed [31:0] key_hi;
  logic [6:0]         rank;
  logic signed [31:0] marks;
  logic signed [31:0] phone;

  modport source (output valid, cmd, key, key_hi, rank, marks, phone, input ready);
  modport sink (input valid, cmd, key, key_hi, rank, marks, phone, output ready);
endinterface

interface slrs_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] rec_key;
  logic signed [31:0] rec_marks;
  logic signed [31:0] rec_phone;
  logic               last;

  modport source (output valid, status, rec_key, rec_marks, rec_phone, last, input ready);
  modport sink (input valid, status, rec_key, rec_marks, rec_phone, last, output ready);
endinterface

// ===== rtl/core/slrs_store.sv =====
module slrs_store #(
  parameter int unsigned NODES     = slrs_pkg::NODES_DEF,
  parameter int unsigned MAX_LEVEL = slrs_pkg::MAX_LEVEL_DEF,
  parameter int unsigned NW        = (NODES > 1) ? $clog2(NODES) : 1,
  parameter int unsigned LW        = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL) : 1,
  parameter int unsigned IW        = $clog2(NODES + 2)
) (
  input  logic                 clk_i,
  input  logic                 rec_we_i,
  input  logic [NW-1:0]        rec_waddr_i,
  input  slrs_pkg::rec_t       rec_wdata_i,
  input  logic                 rec_re_i,
  input  logic [NW-1:0]        rec_raddr_i,
  output slrs_pkg::rec_t       rec_rdata_o,
  input  logic                 link_we_i,
  input  logic [NW-1:0]        link_wnode_i,
  input  logic [LW-1:0]        link_wlvl_i,
  input  logic [IW-1:0]        link_wdata_i,
  input  logic                 link_re_i,
  input  logic [NW-1:0]        link_rnode_i,
  input  logic [LW-1:0]        link_rlvl_i,
  output logic [IW-1:0]        link_rdata_o
);

  localparam int unsigned DEPTH = NODES * MAX_LEVEL;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  slrs_pkg::rec_t rec_mem [NODES];
  logic [IW-1:0]  link_mem [DEPTH];
  logic [AW-1:0]  link_waddr;
  logic [AW-1:0]  link_raddr;

  // row of a node is node * MAX_LEVEL, level selects within the row
  assign link_waddr = AW'(AW'(link_wnode_i) * AW'(MAX_LEVEL) + AW'(link_wlvl_i));
  assign link_raddr = AW'(AW'(link_rnode_i) * AW'(MAX_LEVEL) + AW'(link_rlvl_i));

  always_ff @(posedge clk_i) begin
    if (rec_we_i) begin
      rec_mem[rec_waddr_i] <= rec_wdata_i;
    end
    if (rec_re_i) begin
      rec_rdata_o <= rec_mem[rec_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we_i) begin
      link_mem[link_waddr] <= link_wdata_i;
    end
    if (link_re_i) begin
      link_rdata_o <= link_mem[link_raddr];
    end
  end

endmodule

// ===== rtl/core/skip_list_record_store.sv =====
// channel | dir | port  | handshake   | payload
// command | in  | req_i | valid/ready | cmd, key, key_hi, rank, marks, phone
// result  | out | rsp_o | valid/ready | status, rec_key, rec_marks, rec_phone, last
//
// one command at a time; a search walks the levels from the top down and hops
// along a level while the next key is below the search key
// insert of a new key adds a scan for the lowest free node, a random level draw
// and the linking of the node into each of its levels; range emits record by record
// reset sets head links to list end and top level to 1, clears used map and count and seeds lfsr at once
// a result waits in the output register without blocking the next command
module skip_list_record_store #(
  parameter int unsigned NODES     = slrs_pkg::NODES_DEF,
  parameter int unsigned MAX_LEVEL = slrs_pkg::MAX_LEVEL_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  slrs_req_if.sink     req_i,
  slrs_rsp_if.source   rsp_o
);

  localparam int unsigned IW = $clog2(NODES + 2);
  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned LW = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL) : 1;
  localparam int unsigned TW = $clog2(MAX_LEVEL + 1);
  localparam int unsigned CW = $clog2(NODES + 1);
  localparam int unsigned RW = (CW > 7) ? CW : 7;
  localparam logic [IW-1:0] LIST_END = IW'(NODES);
  localparam logic [IW-1:0] HEAD     = IW'(NODES + 1);

  slrs_pkg::state_e state_q, state_d, ret_q, ret_d;

  logic [2:0]         cmd_q, cmd_d;
  logic signed [31:0] key_q, key_d, hi_q, hi_d, marks_q, marks_d, phone_q, phone_d;
  logic [6:0]         rank_q, rank_d, cnt_q, cnt_d;
  logic [IW-1:0]      p_q, p_d, n_q, n_d;
  logic [LW-1:0]      lv_q, lv_d;
  logic [TW-1:0]      top_q, top_d, lvl_q, lvl_d;
  logic [IW-1:0]      upd_q [MAX_LEVEL];
  logic [IW-1:0]      upd_d [MAX_LEVEL];
  logic [IW-1:0]      head_q [MAX_LEVEL];
  logic [IW-1:0]      head_d [MAX_LEVEL];
  logic [NODES-1:0]   used_q, used_d;
  logic [CW-1:0]      count_q, count_d;
  logic [15:0]        lfsr_q, lfsr_d;
  logic [NW-1:0]      fresh_q, fresh_d;
  slrs_pkg::rec_t     rec_q, rec_d, em_rec_q, em_rec_d, out_q, out_d;
  logic [2:0]         em_st_q, em_st_d, ost_q, ost_d;
  logic               em_last_q, em_last_d, olast_q, olast_d;
  logic               ov_q, ov_d;

  logic                 rec_we, rec_re, link_we, link_re;
  logic [NW-1:0]        rec_waddr, rec_raddr, link_wnode, link_rnode;
  logic [LW-1:0]        link_wlvl, link_rlvl;
  logic [IW-1:0]        link_wdata, link_rdata;
  slrs_pkg::rec_t       rec_wdata, rec_rdata, new_rec;
  logic [IW-1:0]        nxt, u;
  logic                 found;

  slrs_store #(
    .NODES    (NODES),
    .MAX_LEVEL(MAX_LEVEL),
    .NW       (NW),
    .LW       (LW),
    .IW       (IW)
  ) u_store (
    .clk_i       (clk_i),
    .rec_we_i    (rec_we),
    .rec_waddr_i (rec_waddr),
    .rec_wdata_i (rec_wdata),
    .rec_re_i    (rec_re),
    .rec_raddr_i (rec_raddr),
    .rec_rdata_o (rec_rdata),
    .link_we_i   (link_we),
    .link_wnode_i(link_wnode),
    .link_wlvl_i (link_wlvl),
    .link_wdata_i(link_wdata),
    .link_re_i   (link_re),
    .link_rnode_i(link_rnode),
    .link_rlvl_i (link_rlvl),
    .link_rdata_o(link_rdata)
  );

  assign req_i.ready     = (state_q == slrs_pkg::S_IDLE);
  assign rsp_o.valid     = ov_q;
  assign rsp_o.status    = ost_q;
  assign rsp_o.rec_key   = out_q.key;
  assign rsp_o.rec_marks = out_q.marks;
  assign rsp_o.rec_phone = out_q.phone;
  assign rsp_o.last      = olast_q;

  assign new_rec = '{key: key_q, marks: marks_q, phone: phone_q};
  assign found   = (n_q != LIST_END) && (rec_q.key == key_q);
  assign u       = upd_q[lv_q];

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    hi_d      = hi_q;
    marks_d   = marks_q;
    phone_d   = phone_q;
    rank_d    = rank_q;
    cnt_d     = cnt_q;
    p_d       = p_q;
    n_d       = n_q;
    lv_d      = lv_q;
    top_d     = top_q;
    lvl_d     = lvl_q;
    upd_d     = upd_q;
    head_d    = head_q;
    used_d    = used_q;
    count_d   = count_q;
    lfsr_d    = lfsr_q;
    fresh_d   = fresh_q;
    rec_d     = rec_q;
    em_rec_d  = em_rec_q;
    em_st_d   = em_st_q;
    em_last_d = em_last_q;
    out_d     = out_q;
    ost_d     = ost_q;
    olast_d   = olast_q;
    ov_d      = ov_q && !rsp_o.ready;
    rec_we    = 1'b0;
    rec_waddr = NW'(n_q);
    rec_wdata = new_rec;
    rec_re    = 1'b0;
    rec_raddr = NW'(n_q);
    link_we    = 1'b0;
    link_wnode = fresh_q;
    link_wlvl  = lv_q;
    link_wdata = link_rdata;
    link_re    = 1'b0;
    link_rnode = NW'(u);
    link_rlvl  = lv_q;
    nxt        = link_rdata;

    unique case (state_q)
      slrs_pkg::S_IDLE: begin
        if (req_i.valid) begin
          cmd_d   = req_i.cmd;
          key_d   = req_i.key;
          hi_d    = req_i.key_hi;
          rank_d  = req_i.rank;
          marks_d = req_i.marks;
          phone_d = req_i.phone;
          p_d     = HEAD;
          lv_d    = LW'(top_q - TW'(1));
          for (int i = 0; i < MAX_LEVEL; i++) begin
            upd_d[i] = HEAD;
          end
          unique case (req_i.cmd)
            slrs_pkg::CMD_INSERT, slrs_pkg::CMD_SEARCH, slrs_pkg::CMD_DELETE: begin
              state_d = slrs_pkg::S_WALK;
            end
            slrs_pkg::CMD_NTH: begin
              if (req_i.rank == 7'd0 || RW'(req_i.rank) > RW'(count_q)) begin
                em_st_d   = slrs_pkg::ST_NOTFOUND;
                em_rec_d  = '0;
                em_last_d = 1'b1;
                ret_d     = slrs_pkg::S_IDLE;
                state_d   = slrs_pkg::S_EMIT;
              end else begin
                n_d     = head_q[0];
                cnt_d   = 7'd1;
                state_d = slrs_pkg::S_N_LOOP;
              end
            end
            slrs_pkg::CMD_RANGE: begin
              if (slrs_pkg::key_less(req_i.key_hi, req_i.key)) begin
                em_st_d   = slrs_pkg::ST_NOTFOUND;
                em_rec_d  = '0;
                em_last_d = 1'b1;
                ret_d     = slrs_pkg::S_IDLE;
                state_d   = slrs_pkg::S_EMIT;
              end else begin
                state_d = slrs_pkg::S_WALK;
              end
            end
            default: state_d = slrs_pkg::S_IDLE;
          endcase
        end
      end

      slrs_pkg::S_WALK: begin
        link_re    = (p_q != HEAD);
        link_rnode = NW'(p_q);
        state_d    = slrs_pkg::S_WALK_N;
      end

      slrs_pkg::S_WALK_N: begin
        nxt = (p_q == HEAD) ? head_q[lv_q] : link_rdata;
        if (nxt == LIST_END) begin
          upd_d[lv_q] = p_q;
          n_d         = LIST_END;
          if (lv_q == '0) begin
            state_d = slrs_pkg::S_DECIDE;
          end else begin
            lv_d    = lv_q - LW'(1);
            state_d = slrs_pkg::S_WALK;
          end
        end else begin
          n_d       = nxt;
          rec_re    = 1'b1;
          rec_raddr = NW'(nxt);
          state_d   = slrs_pkg::S_WALK_K;
        end
      end

      slrs_pkg::S_WALK_K: begin
        rec_d = rec_rdata;
        if (slrs_pkg::key_less(rec_rdata.key, key_q)) begin
          p_d     = n_q;
          state_d = slrs_pkg::S_WALK;
        end else begin
          upd_d[lv_q] = p_q;
          if (lv_q == '0) begin
            state_d = slrs_pkg::S_DECIDE;
          end else begin
            lv_d    = lv_q - LW'(1);
            state_d = slrs_pkg::S_WALK;
          end
        end
      end

      slrs_pkg::S_DECIDE: begin
        em_last_d = 1'b1;
        ret_d     = slrs_pkg::S_IDLE;
        em_rec_d  = '0;
        em_st_d   = slrs_pkg::ST_NOTFOUND;
        state_d   = slrs_pkg::S_EMIT;
        unique case (cmd_q)
          slrs_pkg::CMD_INSERT: begin
            if (found) begin
              rec_we   = 1'b1;
              em_st_d  = slrs_pkg::ST_UPDATED;
              em_rec_d = new_rec;
            end else if (count_q == CW'(NODES)) begin
              em_st_d = slrs_pkg::ST_FULL;
            end else begin
              fresh_d = '0;
              state_d = slrs_pkg::S_FREE;
            end
          end
          slrs_pkg::CMD_SEARCH: begin
            if (found) begin
              em_st_d  = slrs_pkg::ST_FOUND;
              em_rec_d = rec_q;
            end
          end
          slrs_pkg::CMD_DELETE: begin
            if (found) begin
              lv_d    = '0;
              state_d = slrs_pkg::S_DEL_RD;
            end
          end
          slrs_pkg::CMD_RANGE: state_d = slrs_pkg::S_R_CHECK;
          default:             state_d = slrs_pkg::S_IDLE;
        endcase
      end

      // lowest free node, one bit a cycle
      slrs_pkg::S_FREE: begin
        if (!used_q[fresh_q]) begin
          lvl_d   = TW'(1);
          state_d = slrs_pkg::S_LVL;
        end else begin
          fresh_d = fresh_q + NW'(1);
        end
      end

      slrs_pkg::S_LVL: begin
        if (lvl_q < TW'(MAX_LEVEL)) begin
          lfsr_d = lfsr_q[0] ? ((lfsr_q >> 1) ^ slrs_pkg::LFSR_MASK) : (lfsr_q >> 1);
        end
        if (lvl_q < TW'(MAX_LEVEL) && lfsr_q[0]) begin
          lvl_d = lvl_q + TW'(1);
        end else begin
          if (lvl_q > top_q) begin
            top_d = lvl_q;
          end
          used_d[fresh_q] = 1'b1;
          count_d   = count_q + CW'(1);
          rec_we    = 1'b1;
          rec_waddr = fresh_q;
          lv_d      = '0;
          state_d   = slrs_pkg::S_INS_RD;
        end
      end

      slrs_pkg::S_INS_RD: begin
        link_re = (u != HEAD);
        state_d = slrs_pkg::S_INS_WR;
      end

      slrs_pkg::S_INS_WR: begin
        link_we    = 1'b1;
        link_wdata = (u == HEAD) ? head_q[lv_q] : link_rdata;
        if (u == HEAD) begin
          head_d[lv_q] = IW'(fresh_q);
          if (TW'(lv_q) + TW'(1) == lvl_q) begin
            em_st_d   = slrs_pkg::ST_INSERTED;
            em_rec_d  = new_rec;
            em_last_d = 1'b1;
            ret_d     = slrs_pkg::S_IDLE;
            state_d   = slrs_pkg::S_EMIT;
          end else begin
            lv_d    = lv_q + LW'(1);
            state_d = slrs_pkg::S_INS_RD;
          end
        end else begin
          state_d = slrs_pkg::S_INS_WR2;
        end
      end

      slrs_pkg::S_INS_WR2: begin
        link_we    = 1'b1;
        link_wnode = NW'(u);
        link_wdata = IW'(fresh_q);
        if (TW'(lv_q) + TW'(1) == lvl_q) begin
          em_st_d   = slrs_pkg::ST_INSERTED;
          em_rec_d  = new_rec;
          em_last_d = 1'b1;
          ret_d     = slrs_pkg::S_IDLE;
          state_d   = slrs_pkg::S_EMIT;
        end else begin
          lv_d    = lv_q + LW'(1);
          state_d = slrs_pkg::S_INS_RD;
        end
      end

      slrs_pkg::S_DEL_RD: begin
        link_re = (u != HEAD);
        state_d = slrs_pkg::S_DEL_CHK;
      end

      slrs_pkg::S_DEL_CHK: begin
        nxt = (u == HEAD) ? head_q[lv_q] : link_rdata;
        if (nxt != n_q) begin
          state_d = slrs_pkg::S_DEL_FIN;
        end else begin
          link_re    = 1'b1;
          link_rnode = NW'(n_q);
          state_d    = slrs_pkg::S_DEL_WR;
        end
      end

      slrs_pkg::S_DEL_WR: begin
        if (u == HEAD) begin
          head_d[lv_q] = link_rdata;
        end else begin
          link_we    = 1'b1;
          link_wnode = NW'(u);
        end
        if (TW'(lv_q) + TW'(1) == top_q) begin
          state_d = slrs_pkg::S_DEL_FIN;
        end else begin
          lv_d    = lv_q + LW'(1);
          state_d = slrs_pkg::S_DEL_RD;
        end
      end

      slrs_pkg::S_DEL_FIN: begin
        used_d[NW'(n_q)] = 1'b0;
        if (count_q != '0) begin
          count_d = count_q - CW'(1);
        end
        state_d = slrs_pkg::S_TRIM;
      end

      // drop empty top levels one per cycle
      slrs_pkg::S_TRIM: begin
        if (top_q > TW'(1) && head_q[LW'(top_q - TW'(1))] == LIST_END) begin
          top_d = top_q - TW'(1);
        end else begin
          em_st_d   = slrs_pkg::ST_DELETED;
          em_rec_d  = rec_q;
          em_last_d = 1'b1;
          ret_d     = slrs_pkg::S_IDLE;
          state_d   = slrs_pkg::S_EMIT;
        end
      end

      slrs_pkg::S_N_LOOP: begin
        if (cnt_q == rank_q) begin
          rec_re  = 1'b1;
          state_d = slrs_pkg::S_N_EMIT;
        end else begin
          link_re    = 1'b1;
          link_rnode = NW'(n_q);
          link_rlvl  = '0;
          state_d    = slrs_pkg::S_N_LINK;
        end
      end

      slrs_pkg::S_N_LINK: begin
        n_d     = link_rdata;
        cnt_d   = cnt_q + 7'd1;
        state_d = slrs_pkg::S_N_LOOP;
      end

      slrs_pkg::S_N_EMIT: begin
        em_st_d   = slrs_pkg::ST_FOUND;
        em_rec_d  = rec_rdata;
        em_last_d = 1'b1;
        ret_d     = slrs_pkg::S_IDLE;
        state_d   = slrs_pkg::S_EMIT;
      end

      slrs_pkg::S_R_CHECK: begin
        if (n_q != LIST_END && !slrs_pkg::key_less(hi_q, rec_q.key)) begin
          em_rec_d   = rec_q;
          cnt_d      = 7'd1;
          link_re    = 1'b1;
          link_rnode = NW'(n_q);
          link_rlvl  = '0;
          state_d    = slrs_pkg::S_R_LINK;
        end else begin
          em_st_d   = slrs_pkg::ST_NOTFOUND;
          em_rec_d  = '0;
          em_last_d = 1'b1;
          ret_d     = slrs_pkg::S_IDLE;
          state_d   = slrs_pkg::S_EMIT;
        end
      end

      // current record waits in em_rec until the next one shows whether it is the last
      slrs_pkg::S_R_LINK: begin
        em_st_d = slrs_pkg::ST_FOUND;
        if (link_rdata == LIST_END) begin
          em_last_d = 1'b1;
          ret_d     = slrs_pkg::S_IDLE;
          state_d   = slrs_pkg::S_EMIT;
        end else begin
          n_d       = link_rdata;
          rec_re    = 1'b1;
          rec_raddr = NW'(link_rdata);
          state_d   = slrs_pkg::S_R_REC;
        end
      end

      slrs_pkg::S_R_REC: begin
        em_st_d = slrs_pkg::ST_FOUND;
        state_d = slrs_pkg::S_EMIT;
        if (!slrs_pkg::key_less(hi_q, rec_rdata.key) && cnt_q < 7'(slrs_pkg::RANGE_LIMIT)) begin
          em_last_d = 1'b0;
          ret_d     = slrs_pkg::S_R_NEXT;
        end else begin
          em_last_d = 1'b1;
          ret_d     = slrs_pkg::S_IDLE;
        end
      end

      slrs_pkg::S_R_NEXT: begin
        em_rec_d   = rec_rdata;
        cnt_d      = cnt_q + 7'd1;
        link_re    = 1'b1;
        link_rnode = NW'(n_q);
        link_rlvl  = '0;
        state_d    = slrs_pkg::S_R_LINK;
      end

      slrs_pkg::S_EMIT: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d    = 1'b1;
          out_d   = em_rec_q;
          ost_d   = em_st_q;
          olast_d = em_last_q;
          state_d = ret_q;
        end
      end

      default: state_d = slrs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slrs_pkg::S_IDLE;
      ov_q    <= 1'b0;
      top_q   <= TW'(1);
      used_q  <= '0;
      count_q <= '0;
      lfsr_q  <= slrs_pkg::LFSR_SEED;
      for (int i = 0; i < MAX_LEVEL; i++) begin
        head_q[i] <= LIST_END;
      end
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      top_q   <= top_d;
      used_q  <= used_d;
      count_q <= count_d;
      lfsr_q  <= lfsr_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q     <= ret_d;
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    hi_q      <= hi_d;
    marks_q   <= marks_d;
    phone_q   <= phone_d;
    rank_q    <= rank_d;
    cnt_q     <= cnt_d;
    p_q       <= p_d;
    n_q       <= n_d;
    lv_q      <= lv_d;
    lvl_q     <= lvl_d;
    upd_q     <= upd_d;
    fresh_q   <= fresh_d;
    rec_q     <= rec_d;
    em_rec_q  <= em_rec_d;
    em_st_q   <= em_st_d;
    em_last_q <= em_last_d;
    out_q     <= out_d;
    ost_q     <= ost_d;
    olast_q   <= olast_d;
  end

endmodule

// ===== rtl/core/slrs_checker.sv =====
module slrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  rsp_status_i,
  input logic [31:0] rsp_key_i,
  input logic [31:0] rsp_marks_i,
  input logic [31:0] rsp_phone_i,
  input logic        rsp_last_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_status_i <= slrs_pkg::ST_FULL)
    else $error("status code out of range");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == slrs_pkg::ST_NOTFOUND || rsp_status_i == slrs_pkg::ST_FULL)
    |-> rsp_key_i == '0 && rsp_marks_i == '0 && rsp_phone_i == '0)
    else $error("miss result carries a record");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != slrs_pkg::ST_FOUND |-> rsp_last_i)
    else $error("single-result command without last");

endmodule

bind skip_list_record_store slrs_checker u_slrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_status_i(rsp_o.status),
  .rsp_key_i   (rsp_o.rec_key),
  .rsp_marks_i (rsp_o.rec_marks),
  .rsp_phone_i (rsp_o.rec_phone),
  .rsp_last_i  (rsp_o.last)
);
